@@ hw/rtl/dla_pkg.sv @@
package dla_pkg;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_OWN_SERVER_ID = 3'd0;
    localparam logic [2:0] REG_POOL_SIZE     = 3'd1;
    localparam logic [2:0] REG_LEASE_DEFAULT = 3'd2;
    localparam logic [2:0] REG_LEASE_MAX     = 3'd3;
    localparam logic [2:0] REG_LEASE_MIN     = 3'd4;

    // Register reset values
    localparam logic [15:0] RST_OWN_SERVER_ID = 16'd0;
    localparam logic [8:0]  RST_POOL_SIZE     = 9'd256;
    localparam logic [31:0] RST_LEASE_DEFAULT = 32'd3600;
    localparam logic [31:0] RST_LEASE_MAX     = 32'd7200;
    localparam logic [31:0] RST_LEASE_MIN     = 32'd60;

    // Receiver kinds (code three acts as another server)
    localparam logic [1:0] RCV_THIS  = 2'd0;
    localparam logic [1:0] RCV_BCAST = 2'd1;
    localparam logic [1:0] RCV_OTHER = 2'd2;

    // Message commands
    localparam logic [1:0] CMD_DISCOVER = 2'd0;
    localparam logic [1:0] CMD_REQUEST  = 2'd1;

    // Reply kinds
    localparam logic [1:0] RK_OFFER   = 2'd0;
    localparam logic [1:0] RK_ACK     = 2'd1;
    localparam logic [1:0] RK_REFUSE  = 2'd2;

    // Per-address lease state
    typedef enum logic [1:0] {
        ST_FREE      = 2'd0,
        ST_OFFERED   = 2'd1,
        ST_ALLOCATED = 2'd2,
        ST_EXPIRED   = 2'd3
    } t_addr_state;

    typedef struct packed {
        logic [31:0] time_now;
        logic [15:0] sender_id;
        logic [1:0]  receiver_kind;
        logic [1:0]  command;
        logic [15:0] asked_address;
        logic [31:0] requested_end;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  reply_kind;
        logic [15:0] client_id;
        logic [15:0] reply_address;
        logic [31:0] lease_end;
    } t_out_item;

endpackage

@@ hw/rtl/dla_in_if.sv @@
interface dla_in_if import dla_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/dla_out_if.sv @@
interface dla_out_if import dla_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/dhcp_lease_allocator.sv @@
// An accepted message beat starts a sweep of the lease memory (one entry per cycle on one read
// and one write port, through the read pipeline), then lease math (S_LEN1 to S_LEN3), write-back
// (S_WR1, S_WR2) and hand-off (S_POST); a new message is taken only once back in idle.
// A reply still held at the output holds off the next reply, and so the next message.
// Reset (synchronous, active low) restores the registers, then a clearing pass
// zeroes the lease memory before the first message beat.
module dhcp_lease_allocator import dla_pkg::*; #(
    parameter int ADDRESSES    = 256,
    parameter int HOST_ID_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_data,
    dla_in_if.sink       i_in,
    dla_out_if.source    o_out
);

    localparam int IW = (ADDRESSES > 1) ? $clog2(ADDRESSES) : 1;
    localparam int AW = $clog2(ADDRESSES + 1);
    localparam int HB = HOST_ID_BITS;
    localparam int SB = (HB < 16) ? HB : 16;

    typedef struct packed {
        t_addr_state      st;
        logic             own;
        logic [HB-1:0]    owner;
        logic [31:0]      expiry;
    } t_entry;

    typedef enum logic [8:0] {
        S_CLR  = 9'b000000001,
        S_IDLE = 9'b000000010,
        S_SCAN = 9'b000000100,
        S_LEN1 = 9'b000001000,
        S_LEN2 = 9'b000010000,
        S_LEN3 = 9'b000100000,
        S_WR1  = 9'b001000000,
        S_WR2  = 9'b010000000,
        S_POST = 9'b100000000
    } t_state;

    t_state r_state;

    // Configuration registers
    logic [15:0] r_own;
    logic [8:0]  r_pool;
    logic [31:0] r_ldef, r_lmax, r_lmin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own  <= RST_OWN_SERVER_ID;
            r_pool <= RST_POOL_SIZE;
            r_ldef <= RST_LEASE_DEFAULT;
            r_lmax <= RST_LEASE_MAX;
            r_lmin <= RST_LEASE_MIN;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_OWN_SERVER_ID: r_own  <= i_cfg_data[15:0];
                REG_POOL_SIZE:     r_pool <= i_cfg_data[8:0];
                REG_LEASE_DEFAULT: r_ldef <= i_cfg_data;
                REG_LEASE_MAX:     r_lmax <= i_cfg_data;
                REG_LEASE_MIN:     r_lmin <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Latched message
    logic [31:0]   r_now, r_req;
    logic [HB-1:0] r_sender;
    logic [1:0]    r_recv, r_cmd;
    logic [15:0]   r_asked;

    // Sweep counter and read pipeline
    logic [AW-1:0] r_ra;
    logic          r_rv;
    logic [IW-1:0] r_widx;

    // Lease memory
    t_entry mem [0:ADDRESSES-1];
    t_entry r_rdata;
    logic   w_en;
    logic [IW-1:0] w_idx;
    t_entry w_data;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            mem[w_idx] <= w_data;
        end
        r_rdata <= mem[r_ra[IW-1:0]];
    end

    // Scan results
    logic          r_mfound, r_mpool, r_ffound, r_efound;
    logic [AW-1:0] r_maddr, r_faddr, r_eaddr;
    t_entry        r_mword;

    // Lease length pipeline
    logic signed [33:0] r_diff;
    logic [31:0]        r_len, r_end;
    logic [32:0]        end_sum;

    // Pending result and output register
    logic      r_has;
    t_out_item r_res;
    logic      r_ov;
    t_out_item r_od;

    // Retirement of the entry coming out of the read pipeline
    logic [AW-1:0] cur_addr;
    logic          cur_pool, cur_hit;
    t_entry        cur_new;

    always_comb begin
        cur_addr = AW'(r_widx) + AW'(1);
        cur_pool = (16'(cur_addr) <= 16'(r_pool));
        cur_new  = r_rdata;
        if (cur_pool && (r_rdata.expiry <= r_now)) begin
            if (r_rdata.st == ST_ALLOCATED) begin
                cur_new.st     = ST_EXPIRED;
                cur_new.expiry = '0;
            end else if (r_rdata.st == ST_OFFERED) begin
                cur_new.st     = ST_FREE;
                cur_new.own    = 1'b0;
                cur_new.expiry = '0;
            end
        end
        cur_hit = cur_new.own && (cur_new.owner == r_sender);
    end

    // Message decode and final decision
    logic          is_disc, is_req, is_rel, pick_ok, req_ok, rel_ok;
    logic [AW-1:0] pick;
    logic [HB-1:0] own_h;

    always_comb begin
        own_h   = HB'(r_own[SB-1:0]);
        is_disc = (r_recv == RCV_BCAST) && (r_cmd == CMD_DISCOVER);
        is_req  = (r_recv == RCV_THIS) && (r_cmd == CMD_REQUEST);
        is_rel  = r_recv[1] && (r_cmd == CMD_REQUEST);
        pick_ok = r_mpool || r_ffound || r_efound;
        pick    = r_mpool ? r_maddr : (r_ffound ? r_faddr : r_eaddr);
        req_ok  = r_mpool && (16'(r_maddr) == r_asked);
        rel_ok  = (r_sender != own_h) && r_mpool && (r_mword.st == ST_OFFERED);
    end

    // Memory write port
    always_comb begin
        w_en   = 1'b0;
        w_idx  = r_widx;
        w_data = cur_new;
        case (r_state)
            S_CLR: begin
                w_en   = 1'b1;
                w_idx  = r_ra[IW-1:0];
                w_data = '0;
            end
            S_SCAN: begin
                w_en = r_rv;
            end
            S_WR1: begin
                if (is_disc && pick_ok) begin
                    w_en   = 1'b1;
                    w_idx  = IW'(pick - AW'(1));
                    w_data = '{st: ST_OFFERED, own: 1'b1, owner: r_sender, expiry: r_end};
                end else if (is_req && req_ok) begin
                    w_en   = 1'b1;
                    w_idx  = IW'(r_maddr - AW'(1));
                    w_data = '{st: ST_ALLOCATED, own: 1'b1, owner: r_sender,
                               expiry: r_end};
                end else if (is_rel && rel_ok) begin
                    w_en   = 1'b1;
                    w_idx  = IW'(r_maddr - AW'(1));
                    w_data = '{st: ST_FREE, own: 1'b0, owner: r_mword.owner,
                               expiry: 32'd0};
                end
            end
            S_WR2: begin
                // drop ownership left beyond the active pool
                w_idx      = IW'(r_maddr - AW'(1));
                w_data     = r_mword;
                w_data.own = 1'b0;
                w_en       = is_disc && pick_ok && r_mfound && !r_mpool;
            end
            default: ;
        endcase
    end

    assign end_sum = {1'b0, r_now} + {1'b0, r_len};

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_ra    <= '0;
            r_rv    <= 1'b0;
            r_has   <= 1'b0;
        end else begin
            case (r_state)
                S_CLR: begin
                    r_ra <= r_ra + AW'(1);
                    if (r_ra[IW-1:0] == IW'(ADDRESSES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_now    <= i_in.data.time_now;
                        r_req    <= i_in.data.requested_end;
                        r_sender <= HB'(i_in.data.sender_id[SB-1:0]);
                        r_recv   <= i_in.data.receiver_kind;
                        r_cmd    <= i_in.data.command;
                        r_asked  <= i_in.data.asked_address;
                        r_ra     <= '0;
                        r_rv     <= 1'b0;
                        r_mfound <= 1'b0;
                        r_mpool  <= 1'b0;
                        r_ffound <= 1'b0;
                        r_efound <= 1'b0;
                        r_has    <= 1'b0;
                        r_state  <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // issue one read per cycle, retire and classify one per cycle
                    if (r_ra != AW'(ADDRESSES)) begin
                        r_widx <= r_ra[IW-1:0];
                        r_ra   <= r_ra + AW'(1);
                        r_rv   <= 1'b1;
                    end else begin
                        r_rv <= 1'b0;
                    end
                    if (r_rv) begin
                        if (cur_hit) begin
                            r_mfound <= 1'b1;
                            r_mpool  <= cur_pool;
                            r_maddr  <= cur_addr;
                            r_mword  <= cur_new;
                        end
                        if (cur_pool && !r_ffound && cur_new.st == ST_FREE) begin
                            r_ffound <= 1'b1;
                            r_faddr  <= cur_addr;
                        end
                        if (cur_pool && !r_efound && cur_new.st == ST_EXPIRED) begin
                            r_efound <= 1'b1;
                            r_eaddr  <= cur_addr;
                        end
                    end
                    if (r_ra == AW'(ADDRESSES) && !r_rv) begin
                        r_state <= S_LEN1;
                    end
                end
                S_LEN1: begin
                    r_diff  <= $signed({2'b00, r_req}) - $signed({2'b00, r_now});
                    r_state <= S_LEN2;
                end
                S_LEN2: begin
                    if (r_req == 32'd0) begin
                        r_len <= r_ldef;
                    end else if (r_diff < $signed({2'b00, r_lmin})) begin
                        r_len <= r_lmin;
                    end else if (r_diff > $signed({2'b00, r_lmax})) begin
                        r_len <= r_lmax;
                    end else begin
                        r_len <= r_diff[31:0];
                    end
                    r_state <= S_LEN3;
                end
                S_LEN3: begin
                    r_end   <= end_sum[32] ? '1 : end_sum[31:0];
                    r_state <= S_WR1;
                end
                S_WR1: begin
                    r_res.client_id <= 16'(r_sender);
                    if (is_disc && pick_ok) begin
                        r_has               <= 1'b1;
                        r_res.reply_kind    <= RK_OFFER;
                        r_res.reply_address <= 16'(pick);
                        r_res.lease_end     <= r_end;
                    end else if (is_req) begin
                        r_has               <= 1'b1;
                        r_res.reply_kind    <= req_ok ? RK_ACK : RK_REFUSE;
                        r_res.reply_address <= r_asked;
                        r_res.lease_end     <= req_ok ? r_end : 32'd0;
                    end
                    r_state <= S_WR2;
                end
                S_WR2: begin
                    r_state <= S_POST;
                end
                S_POST: begin
                    if (!r_has || !r_ov || o_out.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (r_state == S_POST && r_has && (!r_ov || o_out.ready)) begin
            r_ov <= 1'b1;
            r_od <= r_res;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_ov;
    assign o_out.data  = r_od;

    // Checks
    a_no_beat_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> !i_in.ready)
        else $error("message taken during clearing pass");

    a_beat_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == S_SCAN))
        else $error("accepted beat did not start a sweep");

    a_refuse_zero_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.reply_kind == RK_REFUSE)
            |-> (o_out.data.lease_end == 32'd0))
        else $error("refusal with nonzero lease end");

    a_reply_kinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.data.reply_kind == RK_OFFER ||
                         o_out.data.reply_kind == RK_ACK ||
                         o_out.data.reply_kind == RK_REFUSE))
        else $error("bad reply kind");

endmodule
